// ===== sv/bis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and codes of the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_SRC_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_SRC_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_SRC_SPAN_X   = 3'd2;
  localparam logic [2:0] CFG_SRC_SPAN_Y   = 3'd3;
  localparam logic [2:0] CFG_DST_SPAN_X   = 3'd4;
  localparam logic [2:0] CFG_DST_SPAN_Y   = 3'd5;
  localparam logic [2:0] CFG_CHANNEL_MODE = 3'd6;

  // request kinds
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // channel modes
  localparam logic [1:0] CH_ONE   = 2'd0;
  localparam logic [1:0] CH_THREE = 2'd1;

  localparam int COORD_W = 10;
  localparam int SPAN_W  = 8;
  localparam int PIX_W   = 32;

  typedef struct packed {
    logic [7:0] src_origin_x;
    logic [7:0] src_origin_y;
    logic [7:0] src_span_x;
    logic [7:0] src_span_y;
    logic [9:0] dst_span_x;
    logic [9:0] dst_span_y;
    logic [1:0] channel_mode;
  } cfg_t;

endpackage

// ===== sv/bis_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bis_stepdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_stepdiv
// Restoring divider for the per-axis step: (span << FRAC_BITS) / den.
// One quotient bit per cycle; a zero divisor gives a zero step.
// ----------------------------------------------------------------------------
module bis_stepdiv #(
  parameter int FRAC_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [bis_pkg::SPAN_W-1:0]      span,
  input  logic [bis_pkg::COORD_W-1:0]     den,
  output logic                            busy,
  output logic [bis_pkg::SPAN_W+FRAC_BITS-1:0] quot
);

  localparam int NW = bis_pkg::SPAN_W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam int DW = bis_pkg::COORD_W;

  logic [NW-1:0] num_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, num_r[NW-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(NW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {span, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[NW-2:0], fits};
      rem_r <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
    end
  end

  assign busy = (cnt_r != '0);
  assign quot = (den_r == '0) ? '0 : num_r;

endmodule

// ===== sv/bis_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_front
// Accepts requests, clamps query coordinates, forms the fixed-point source
// positions (coordinate times step), one request per cycle barring stalls.
// ----------------------------------------------------------------------------
module bis_front #(
  parameter int FRAC_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bis_pkg::cfg_t          cfg,
  input  logic                   step_busy,
  input  logic [bis_pkg::SPAN_W+FRAC_BITS-1:0] step_x,
  input  logic [bis_pkg::SPAN_W+FRAC_BITS-1:0] step_y,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   in_tuser,
  input  logic [55:0]            in_tdata,
  output logic                   push,
  output logic [2*(bis_pkg::COORD_W+bis_pkg::SPAN_W+FRAC_BITS)+53-1:0] push_data,
  input  logic                   q_full
);

  localparam int CWD = bis_pkg::COORD_W;
  localparam int PW  = CWD + bis_pkg::SPAN_W + FRAC_BITS;

  logic [CWD-1:0] cx, cy, qx, qy;
  logic [31:0]    pix;
  logic           f_valid_r, f_valid_nxt;
  logic           f_mode_r;
  logic [CWD-1:0] f_cx_r, f_cy_r;
  logic [31:0]    f_pix_r;
  logic [PW-1:0]  f_px_r, f_py_r;

  assign cx  = in_tdata[9:0];
  assign cy  = in_tdata[19:10];
  assign pix = in_tdata[51:20];
  assign qx  = (cx > cfg.dst_span_x) ? cfg.dst_span_x : cx;
  assign qy  = (cy > cfg.dst_span_y) ? cfg.dst_span_y : cy;

  assign push      = f_valid_r && !q_full;
  assign in_tready = !step_busy && (!f_valid_r || !q_full);

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (push) begin
      f_valid_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      f_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      f_mode_r <= in_tuser;
      f_cx_r   <= cx;
      f_cy_r   <= cy;
      f_pix_r  <= pix;
      f_px_r   <= PW'(qx * step_x);
      f_py_r   <= PW'(qy * step_y);
    end
  end

  // lowest up: mode, cx, cy, pixel, px, py
  assign push_data = {f_py_r, f_px_r, f_pix_r, f_cy_r, f_cx_r, f_mode_r};

endmodule

// ===== sv/bis_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_fifo
// Short request queue between front and back end.
// ----------------------------------------------------------------------------
module bis_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] buf_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign head  = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== sv/bis_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_back
// Store access and blend pipeline. The store is split into four banks by
// row and column parity so the four neighbors are read in the same cycle.
// ----------------------------------------------------------------------------
module bis_back #(
  parameter int STORE_WIDTH  = 256,
  parameter int STORE_HEIGHT = 256,
  parameter int FRAC_BITS    = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bis_pkg::cfg_t       cfg,
  input  logic [2*(bis_pkg::COORD_W+bis_pkg::SPAN_W+FRAC_BITS)+53-1:0] head,
  input  logic                empty,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata
);

  localparam int CWD    = bis_pkg::COORD_W;
  localparam int PW     = CWD + bis_pkg::SPAN_W + FRAC_BITS;
  localparam int IW     = PW - FRAC_BITS + 1;
  localparam int XW     = $clog2(STORE_WIDTH);
  localparam int YW     = $clog2(STORE_HEIGHT);
  localparam int HALF_W = (STORE_WIDTH + 1) / 2;
  localparam int HALF_H = (STORE_HEIGHT + 1) / 2;
  localparam int BDEPTH = HALF_W * HALF_H;
  localparam int AW     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int WW     = 2 * FRAC_BITS + 1;
  localparam int MW     = WW + 8;
  localparam int SW     = WW + 10;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  // queue head fields
  logic           h_mode;
  logic [CWD-1:0] h_cx, h_cy;
  logic [31:0]    h_pix;
  logic [PW-1:0]  h_px, h_py;
  assign {h_py, h_px, h_pix, h_cy, h_cx, h_mode} = head;

  logic en;
  assign en  = !out_tvalid || out_tready;
  assign pop = en && !empty;

  // neighbor coordinates, clamped to the store
  logic [IW-1:0] sx, sy, sx1, sy1;
  logic [XW-1:0] x0, x1;
  logic [YW-1:0] y0, y1;
  assign sx  = IW'(cfg.src_origin_x) + IW'(h_px >> FRAC_BITS);
  assign sy  = IW'(cfg.src_origin_y) + IW'(h_py >> FRAC_BITS);
  assign sx1 = sx + 1'b1;
  assign sy1 = sy + 1'b1;
  assign x0  = (32'(sx)  > 32'(STORE_WIDTH - 1))  ? XW'(STORE_WIDTH - 1)  : XW'(sx);
  assign x1  = (32'(sx1) > 32'(STORE_WIDTH - 1))  ? XW'(STORE_WIDTH - 1)  : XW'(sx1);
  assign y0  = (32'(sy)  > 32'(STORE_HEIGHT - 1)) ? YW'(STORE_HEIGHT - 1) : YW'(sy);
  assign y1  = (32'(sy1) > 32'(STORE_HEIGHT - 1)) ? YW'(STORE_HEIGHT - 1) : YW'(sy1);

  logic       is_load, load_ok;
  logic [AW-1:0] w_addr;
  assign is_load = (h_mode == bis_pkg::MODE_LOAD);
  assign load_ok = (32'(h_cx) < 32'(STORE_WIDTH)) && (32'(h_cy) < 32'(STORE_HEIGHT));
  assign w_addr  = AW'((32'(h_cy) >> 1) * 32'(HALF_W) + (32'(h_cx) >> 1));

  // bank index is {row parity, column parity}
  logic [AW-1:0] r_addr [4];
  logic [31:0]   r_data [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [31:0] col_h, row_h;
    logic        bwe;
    assign col_h = (x0[0] == b[0]) ? (32'(x0) >> 1) : (32'(x1) >> 1);
    assign row_h = (y0[0] == b[1]) ? (32'(y0) >> 1) : (32'(y1) >> 1);
    assign r_addr[b] = AW'(row_h * 32'(HALF_W) + col_h);
    assign bwe = pop && is_load && load_ok
                 && (h_cx[0] == b[0]) && (h_cy[0] == b[1]);

    bis_ram #(
      .WIDTH (32),
      .DEPTH (BDEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bwe),
      .waddr (w_addr),
      .wdata (h_pix),
      .re    (pop && !is_load),
      .raddr (r_addr[b]),
      .rdata (r_data[b])
    );
  end

  // stage 1: read in flight
  logic                 v1_r, m1_r;
  logic [FRAC_BITS-1:0] tx1_r, ty1_r;
  logic                 px0_r, px1_r, py0_r, py1_r;

  // stage 2: weights and neighbor pixels
  logic          v2_r, m2_r;
  logic [WW-1:0] w2_r [4];
  logic [31:0]   p2_r [4];

  // stage 3: per-channel products
  logic          v3_r, m3_r;
  logic [MW-1:0] prod_r [4][4];

  logic [FRAC_BITS:0] itx, ity;
  assign itx = ONE - {1'b0, tx1_r};
  assign ity = ONE - {1'b0, ty1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (en) begin
      v1_r <= !empty;
      v2_r <= v1_r;
      v3_r <= v2_r;
      out_tvalid <= v3_r;
    end
  end

  logic [SW-1:0] acc [4];
  logic [31:0]   res;
  always_comb begin
    res = '0;
    for (int c = 0; c < 4; c++) begin
      acc[c] = SW'(prod_r[c][0]) + SW'(prod_r[c][1]) + SW'(prod_r[c][2])
             + SW'(prod_r[c][3]);
      res[8*c +: 8] = acc[c][2*FRAC_BITS +: 8];
    end
    case (cfg.channel_mode)
      bis_pkg::CH_ONE:   res[31:8]  = '0;
      bis_pkg::CH_THREE: res[31:24] = '0;
      default: ;
    endcase
    if (m3_r == bis_pkg::MODE_LOAD) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r  <= h_mode;
      tx1_r <= h_px[FRAC_BITS-1:0];
      ty1_r <= h_py[FRAC_BITS-1:0];
      px0_r <= x0[0];
      px1_r <= x1[0];
      py0_r <= y0[0];
      py1_r <= y1[0];

      m2_r    <= m1_r;
      w2_r[0] <= WW'(itx * ity);
      w2_r[1] <= WW'({1'b0, tx1_r} * ity);
      w2_r[2] <= WW'(itx * {1'b0, ty1_r});
      w2_r[3] <= WW'({1'b0, tx1_r} * {1'b0, ty1_r});
      p2_r[0] <= r_data[{py0_r, px0_r}];
      p2_r[1] <= r_data[{py0_r, px1_r}];
      p2_r[2] <= r_data[{py1_r, px0_r}];
      p2_r[3] <= r_data[{py1_r, px1_r}];

      m3_r <= m2_r;
      for (int c = 0; c < 4; c++) begin
        for (int n = 0; n < 4; n++) begin
          prod_r[c][n] <= MW'(w2_r[n] * p2_r[n][8*c +: 8]);
        end
      end

      if (v3_r) begin
        out_tdata <= res;
      end
    end
  end

endmodule

// ===== sv/bilinear_image_scaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// Source pixel store with bilinear blending of destination pixels.
// ----------------------------------------------------------------------------
// Takes one request (load or query) per cycle while not held off, and returns
// one result per request, in order. The four neighbors come from four parity
// banks of the store in one read, so apart from the step recompute the rate
// is bound by nothing but backpressure. After reset and after each write of a
// span register the steps are recomputed by two serial dividers, one bit per
// cycle, and requests are held off until both are done. The store is not
// cleared; query only pixels loaded.
module bilinear_image_scaler #(
  parameter int STORE_WIDTH  = 256,
  parameter int STORE_HEIGHT = 256,
  parameter int FRAC_BITS    = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // mode
  input  logic [55:0] in_tdata,   // coord_x, coord_y, pixel_in, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // pixel_out
);

  localparam int SWD = bis_pkg::SPAN_W + FRAC_BITS;
  localparam int EW  = 2 * (bis_pkg::COORD_W + SWD) + 53;

  bis_pkg::cfg_t cfg_r;
  logic          start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_origin_x <= 8'd0;
      cfg_r.src_origin_y <= 8'd0;
      cfg_r.src_span_x   <= 8'd255;
      cfg_r.src_span_y   <= 8'd255;
      cfg_r.dst_span_x   <= 10'd255;
      cfg_r.dst_span_y   <= 10'd255;
      cfg_r.channel_mode <= 2'd2;
      start_r            <= 1'b1;
    end else begin
      // any span write restarts the step dividers
      start_r <= cfg_we && (cfg_addr inside {bis_pkg::CFG_SRC_SPAN_X, bis_pkg::CFG_SRC_SPAN_Y,
                                             bis_pkg::CFG_DST_SPAN_X, bis_pkg::CFG_DST_SPAN_Y});
      if (cfg_we) begin
        case (cfg_addr)
          bis_pkg::CFG_SRC_ORIGIN_X: cfg_r.src_origin_x <= cfg_wdata[7:0];
          bis_pkg::CFG_SRC_ORIGIN_Y: cfg_r.src_origin_y <= cfg_wdata[7:0];
          bis_pkg::CFG_SRC_SPAN_X:   cfg_r.src_span_x   <= cfg_wdata[7:0];
          bis_pkg::CFG_SRC_SPAN_Y:   cfg_r.src_span_y   <= cfg_wdata[7:0];
          bis_pkg::CFG_DST_SPAN_X:   cfg_r.dst_span_x   <= cfg_wdata;
          bis_pkg::CFG_DST_SPAN_Y:   cfg_r.dst_span_y   <= cfg_wdata;
          bis_pkg::CFG_CHANNEL_MODE: cfg_r.channel_mode <= cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
  end

  logic           busy_x, busy_y, step_busy;
  logic [SWD-1:0] step_x, step_y;

  bis_stepdiv #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .span  (cfg_r.src_span_x),
    .den   (cfg_r.dst_span_x),
    .busy  (busy_x),
    .quot  (step_x)
  );

  bis_stepdiv #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .span  (cfg_r.src_span_y),
    .den   (cfg_r.dst_span_y),
    .busy  (busy_y),
    .quot  (step_y)
  );

  assign step_busy = start_r || busy_x || busy_y;

  logic          push, pop, q_empty, q_full;
  logic [EW-1:0] push_data, head;

  bis_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step_busy (step_busy),
    .step_x    (step_x),
    .step_y    (step_y),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  bis_fifo #(.WIDTH(EW), .DEPTH(4)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  bis_back #(
    .STORE_WIDTH  (STORE_WIDTH),
    .STORE_HEIGHT (STORE_HEIGHT),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
